// ===== src/canonical_kmer_bloom_filter_unit_assert.svh =====
// Assertion macros for the canonical k-mer Bloom filter unit.
// Included by the RTL files that check their own logic; needs nothing else.
`ifndef CANONICAL_KMER_BLOOM_FILTER_UNIT_ASSERT_SVH
`define CANONICAL_KMER_BLOOM_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CKBF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ckbf: same-cycle check failed");
`define CKBF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ckbf: next-cycle check failed");
`else
`define CKBF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CKBF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/ckbf_pkg.sv =====
// Shared constants, types and functions of the canonical k-mer Bloom filter unit.
// No dependencies; all files but the assertion header and ckbf_ram import this package.
`default_nettype none
package ckbf_pkg;

  localparam int MAX_KMER     = 64;
  localparam int MAX_HASHES   = 8;
  localparam int NUM_FILTERS  = 8;
  localparam int FILTER_WORDS = 16384;

  localparam int KLEN_W  = 7;
  localparam int HC_W    = 4;
  localparam int FS_W    = 21;
  localparam int PART_W  = 3;
  localparam int WIDX_W  = 14;
  localparam int KADDR_W = $clog2(MAX_KMER);
  localparam int FADDR_W = $clog2(NUM_FILTERS * FILTER_WORDS);
  localparam int KEY_W   = MAX_KMER * 8;
  localparam int BLK_W   = $clog2(MAX_KMER / 8) + 1;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
  localparam int MIX_R = 47;
  localparam logic [FS_W-1:0] MAX_BITS = FS_W'(FILTER_WORDS * 64);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 2'd2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  localparam logic [7:0] ASC_A  = 8'h41;
  localparam logic [7:0] ASC_C  = 8'h43;
  localparam logic [7:0] ASC_G  = 8'h47;
  localparam logic [7:0] ASC_T  = 8'h54;
  localparam logic [7:0] ASC_N  = 8'h4e;
  localparam logic [7:0] ASC_LA = 8'h61;
  localparam logic [7:0] ASC_LC = 8'h63;
  localparam logic [7:0] ASC_LG = 8'h67;
  localparam logic [7:0] ASC_LT = 8'h74;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_KMER  = 2'd1,
    CMD_SHORT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               insert;
    logic [PART_W-1:0]  partition;
    logic [WIDX_W-1:0]  word_index;
    logic [63:0]        word_bits;
  } cmd_t;

  typedef struct packed {
    logic [KLEN_W-1:0] klen;
    logic [HC_W-1:0]   nh;
    logic [FS_W-1:0]   fs;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [KADDR_W-1:0] addr;
    logic [7:0]         data;
  } kbuf_wr_t;

  function automatic logic [7:0] comp_base(input logic [7:0] x);
    logic [7:0] y;
    unique case (x) inside
      ASC_A, ASC_LA: y = ASC_T;
      ASC_C, ASC_LC: y = ASC_G;
      ASC_G, ASC_LG: y = ASC_C;
      ASC_T, ASC_LT: y = ASC_A;
      default:       y = ASC_N;
    endcase
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== src/ckbf_channels.sv =====
// Channel interfaces of the canonical k-mer Bloom filter unit: items, results, config.
// Depends on ckbf_pkg for field widths.
`default_nettype none
interface ckbf_item_if import ckbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [PART_W-1:0] partition;
  logic [7:0]        kmer_char;
  logic              kmer_last;
  logic [WIDX_W-1:0] word_index;
  logic [63:0]       word_bits;
  modport source (output valid, op, partition, kmer_char, kmer_last, word_index, word_bits,
                  input ready);
  modport sink (input valid, op, partition, kmer_char, kmer_last, word_index, word_bits,
                output ready);
endinterface

interface ckbf_result_if ();
  logic valid;
  logic ready;
  logic found;
  logic length_error;
  logic was_insert;
  modport source (output valid, found, length_error, was_insert, input ready);
  modport sink (input valid, found, length_error, was_insert, output ready);
endinterface

interface ckbf_cfg_if import ckbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/canonical_kmer_bloom_filter_unit.sv =====
// Top level of the canonical k-mer Bloom filter unit: config registers, buffers, parts.
// Depends on ckbf_pkg, the channel interfaces, ckbf_ram, ckbf_fifo, ckbf_front, ckbf_back.
//
// Usage. Items enter on the item channel and each accepted transaction is one load of a
// 64-bit filter word (op 0), one k-mer character for a query (op 1) or for an insert
// (op 2). Op 3 is accepted and dropped. The item with kmer_last finishes the k-mer and
// causes exactly one transaction on the result channel; loads and other characters cause
// none. Config writes come on the cfg channel, which is always ready; the user must make
// them only while the unit is idle, as the unit itself does not enforce this.
// Timing. Characters and loads are taken one per cycle while the command queue is not full.
// Once a full k-mer of k characters is queued, further characters stall until its result is
// produced; loads keep being queued while the queue has room. A k-mer is first made
// canonical by comparing mirror pairs of its characters and then, per hash seed, passes
// through the shared 64-bit constant multiplier, the bit-serial remainder unit and the
// filter probe. A short k-mer skips these steps and reports length_error.
// The result sits in an output register; while the receiver stalls, the back part holds
// the next result and the front part keeps queuing up to four commands.
// Reset clears the character count, the queue and all handshakes and restores the config
// registers (kmer_len 32, hash_count 4, filter_size 1048576). Filter words are undefined
// until loaded; no clearing pass runs.
`default_nettype none
module canonical_kmer_bloom_filter_unit import ckbf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  ckbf_item_if.sink     item,
  ckbf_result_if.source result,
  ckbf_cfg_if.sink      cfg
);
  logic [KLEN_W-1:0] kmer_len;
  logic [HC_W-1:0]   hash_count;
  logic [FS_W-1:0]   filter_size;
  cfg_t              eff_cfg;

  kbuf_wr_t          kbuf_wr;
  logic              cmd_push;
  cmd_t              cmd_in;
  logic              cmd_full;
  logic              cmd_pop;
  cmd_t              cmd_out;
  logic              cmd_empty;
  logic              kmer_done;
  logic [KADDR_W-1:0] kbuf_raddr_a;
  logic [KADDR_W-1:0] kbuf_raddr_b;
  logic [7:0]        kbuf_rdata_a;
  logic [7:0]        kbuf_rdata_b;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len    <= KLEN_W'(32);
      hash_count  <= HC_W'(4);
      filter_size <= MAX_BITS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KMER_LEN:    kmer_len    <= cfg.data[KLEN_W-1:0];
        REG_HASH_COUNT:  hash_count  <= cfg.data[HC_W-1:0];
        REG_FILTER_SIZE: filter_size <= cfg.data[FS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are clamped into the legal range.
  always_comb begin
    if (kmer_len == '0) begin
      eff_cfg.klen = KLEN_W'(1);
    end else if (kmer_len > KLEN_W'(MAX_KMER)) begin
      eff_cfg.klen = KLEN_W'(MAX_KMER);
    end else begin
      eff_cfg.klen = kmer_len;
    end
    eff_cfg.nh = (hash_count > HC_W'(MAX_HASHES)) ? HC_W'(MAX_HASHES) : hash_count;
    if (filter_size == '0) begin
      eff_cfg.fs = FS_W'(1);
    end else if (filter_size > MAX_BITS) begin
      eff_cfg.fs = MAX_BITS;
    end else begin
      eff_cfg.fs = filter_size;
    end
  end

  // Two copies of the character buffer give the mirror compare two read ports.
  ckbf_ram #(.WIDTH(8), .DEPTH(MAX_KMER)) u_kbuf_a (
    .clk   (clk),
    .we    (kbuf_wr.we),
    .waddr (kbuf_wr.addr),
    .wdata (kbuf_wr.data),
    .raddr (kbuf_raddr_a),
    .rdata (kbuf_rdata_a)
  );

  ckbf_ram #(.WIDTH(8), .DEPTH(MAX_KMER)) u_kbuf_b (
    .clk   (clk),
    .we    (kbuf_wr.we),
    .waddr (kbuf_wr.addr),
    .wdata (kbuf_wr.data),
    .raddr (kbuf_raddr_b),
    .rdata (kbuf_rdata_b)
  );

  ckbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (eff_cfg),
    .item      (item),
    .kbuf_wr   (kbuf_wr),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full),
    .kmer_done (kmer_done)
  );

  ckbf_fifo u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  ckbf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (eff_cfg),
    .cmd_data     (cmd_out),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .kbuf_raddr_a (kbuf_raddr_a),
    .kbuf_raddr_b (kbuf_raddr_b),
    .kbuf_rdata_a (kbuf_rdata_a),
    .kbuf_rdata_b (kbuf_rdata_b),
    .kmer_done    (kmer_done),
    .result       (result)
  );
endmodule
`default_nettype wire

// ===== src/ckbf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module ckbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/ckbf_fifo.sv =====
// Short command queue between the front and back parts of the unit.
// Depends on ckbf_pkg and the assertion header.
`default_nettype none
`include "canonical_kmer_bloom_filter_unit_assert.svh"
module ckbf_fifo import ckbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);
  cmd_t                  mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;

  assign full     = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CKBF_ASSERT_IMP(a_no_overflow, clk, rst, push, !full)
endmodule
`default_nettype wire

// ===== src/ckbf_mulm.sv =====
// Multiplier by the mixing constant, modulo 2^64, from three 32x32 partial products.
// Depends on ckbf_pkg.
`default_nettype none
module ckbf_mulm import ckbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  output logic             busy,
  output logic             done,
  output logic      [63:0] p
);
  localparam logic [1:0] LAST_STEP = 2'd2;

  logic [1:0]  step;
  logic [63:0] opa;
  logic [63:0] acc;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] prod;

  always_comb begin
    case (step)
      2'd0: begin
        x = opa[31:0];
        y = MIX_M[31:0];
      end
      2'd1: begin
        x = opa[63:32];
        y = MIX_M[31:0];
      end
      default: begin
        x = opa[31:0];
        y = MIX_M[63:32];
      end
    endcase
    prod = 64'(x) * 64'(y);
  end

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opa <= a;
    end else if (busy) begin
      if (step == '0) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/ckbf_front.sv =====
// Front part: accepts items, gathers k-mer characters and queues commands.
// Depends on ckbf_pkg, the channel interfaces and the assertion header.
`default_nettype none
`include "canonical_kmer_bloom_filter_unit_assert.svh"
module ckbf_front import ckbf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cfg_t       cfg,
  ckbf_item_if.sink  item,
  output kbuf_wr_t   kbuf_wr,
  output logic       cmd_push,
  output cmd_t       cmd_data,
  input  wire logic  cmd_full,
  input  wire logic  kmer_done
);
  logic [KLEN_W-1:0] char_count;
  logic              pending;
  logic              is_char;
  logic              accept;
  logic              take_char;
  logic [KLEN_W-1:0] cc_after;

  assign is_char   = (item.op == OP_QUERY) || (item.op == OP_INSERT);
  // The buffer belongs to the back part while a full k-mer waits there.
  assign item.ready = !cmd_full && !(pending && is_char);
  assign accept    = item.valid && item.ready;
  assign take_char = accept && is_char && (char_count < cfg.klen);
  assign cc_after  = char_count + KLEN_W'(take_char);

  assign kbuf_wr.we   = take_char;
  assign kbuf_wr.addr = char_count[KADDR_W-1:0];
  assign kbuf_wr.data = item.kmer_char;

  assign cmd_push = accept && ((item.op == OP_LOAD) || (is_char && item.kmer_last));

  always_comb begin
    cmd_data.insert     = (item.op == OP_INSERT);
    cmd_data.partition  = item.partition;
    cmd_data.word_index = item.word_index;
    cmd_data.word_bits  = item.word_bits;
    if (item.op == OP_LOAD) begin
      cmd_data.kind = CMD_LOAD;
    end else if (cc_after < cfg.klen) begin
      cmd_data.kind = CMD_SHORT;
    end else begin
      cmd_data.kind = CMD_KMER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      pending    <= 1'b0;
    end else begin
      if (accept && is_char) begin
        char_count <= item.kmer_last ? '0 : cc_after;
      end
      if (kmer_done) begin
        pending <= 1'b0;
      end else if (cmd_push && cmd_data.kind == CMD_KMER) begin
        pending <= 1'b1;
      end
    end
  end

  `CKBF_ASSERT_IMP(a_done_only_pending, clk, rst, kmer_done, pending)
endmodule
`default_nettype wire

// ===== src/ckbf_back.sv =====
// Back part: loads filter words, canonicalizes and hashes k-mers, probes the filters.
// Depends on ckbf_pkg, ckbf_ram, ckbf_mulm, the channel interfaces and the assertion header.
`default_nettype none
`include "canonical_kmer_bloom_filter_unit_assert.svh"
module ckbf_back import ckbf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd_data,
  input  wire logic                cmd_empty,
  output logic                     cmd_pop,
  output logic     [KADDR_W-1:0]   kbuf_raddr_a,
  output logic     [KADDR_W-1:0]   kbuf_raddr_b,
  input  wire logic [7:0]          kbuf_rdata_a,
  input  wire logic [7:0]          kbuf_rdata_b,
  output logic                     kmer_done,
  ckbf_result_if.source            result
);
  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_CANON_RD  = 17'h00002,
    S_CANON_CMP = 17'h00004,
    S_KEY_RD    = 17'h00008,
    S_KEY_LAST  = 17'h00010,
    S_H_INIT    = 17'h00020,
    S_H_SEED    = 17'h00040,
    S_H_NEXT    = 17'h00080,
    S_BLK1      = 17'h00100,
    S_BLK2      = 17'h00200,
    S_BLK3      = 17'h00400,
    S_TAIL      = 17'h00800,
    S_FIN       = 17'h01000,
    S_MOD       = 17'h02000,
    S_PROBE_RD  = 17'h04000,
    S_PROBE_CHK = 17'h08000,
    S_EMIT      = 17'h10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [PART_W-1:0]   part;
  logic                ins;
  logic                is_kmer;
  logic                len_err;
  logic                found;
  logic [KADDR_W-1:0]  pidx;
  logic [KADDR_W-1:0]  jidx;
  logic [KADDR_W-1:0]  jd;
  logic                kv;
  logic                swap;
  logic [KEY_W-1:0]    key;
  logic [HC_W-1:0]     seed;
  logic [BLK_W-1:0]    blk;
  logic [63:0]         h;
  logic [63:0]         dvd;
  logic [FS_W-1:0]     rem;
  logic [5:0]          bcnt;

  logic [KADDR_W-1:0]  kl1;
  logic [KADDR_W-1:0]  half;
  logic [BLK_W-1:0]    whole;
  logic [2:0]          tail_len;
  logic [7:0]          ca;
  logic [7:0]          cb;
  logic [FS_W:0]       r2;
  logic                can_emit;

  logic                mstart;
  logic [63:0]         ma;
  logic                mbusy;
  logic                mdone;
  logic [63:0]         mp;

  logic                fwe;
  logic [FADDR_W-1:0]  fwaddr;
  logic [63:0]         fwdata;
  logic [FADDR_W-1:0]  fraddr;
  logic [63:0]         frdata;
  logic [63:0]         mask;

  assign kl1      = KADDR_W'(cfg.klen - KLEN_W'(1));
  assign half     = kl1 >> 1;
  assign whole    = BLK_W'(cfg.klen >> 3);
  assign tail_len = cfg.klen[2:0];
  assign ca       = kbuf_rdata_a;
  assign cb       = comp_base(kbuf_rdata_b);
  assign r2       = {rem, dvd[63]};
  assign can_emit = !result.valid || result.ready;
  assign mask     = 64'd1 << (6'd63 - rem[5:0]);
  assign fraddr   = {part, rem[WIDX_W+5:6]};

  function automatic logic [63:0] block(input logic [KEY_W-1:0] k, input logic [BLK_W-2:0] i);
    return k[i*64 +: 64];
  endfunction

  function automatic logic [63:0] fold(input logic [63:0] v);
    return v ^ (v >> MIX_R);
  endfunction

  ckbf_mulm u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma),
    .busy  (mbusy),
    .done  (mdone),
    .p     (mp)
  );

  ckbf_ram #(.WIDTH(64), .DEPTH(NUM_FILTERS * FILTER_WORDS)) u_filter (
    .clk   (clk),
    .we    (fwe),
    .waddr (fwaddr),
    .wdata (fwdata),
    .raddr (fraddr),
    .rdata (frdata)
  );

  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    mstart       = 1'b0;
    ma           = h;
    fwe          = 1'b0;
    fwaddr       = fraddr;
    fwdata       = frdata | mask;
    kmer_done    = 1'b0;
    kbuf_raddr_a = jidx;
    kbuf_raddr_b = kl1 - jidx;
    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd_data.kind)
            CMD_LOAD: begin
              fwe    = 1'b1;
              fwaddr = {cmd_data.partition, cmd_data.word_index};
              fwdata = cmd_data.word_bits;
            end
            CMD_KMER:  state_next = S_CANON_RD;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_CANON_RD: begin
        kbuf_raddr_a = pidx;
        kbuf_raddr_b = kl1 - pidx;
        state_next   = S_CANON_CMP;
      end
      S_CANON_CMP: begin
        if (pidx < half && ca == cb) begin
          state_next = S_CANON_RD;
        end else begin
          state_next = S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        if (jidx == kl1) begin
          state_next = S_KEY_LAST;
        end
      end
      S_KEY_LAST: begin
        state_next = (cfg.nh == '0) ? S_EMIT : S_H_INIT;
      end
      S_H_INIT: begin
        mstart     = 1'b1;
        ma         = 64'(cfg.klen);
        state_next = S_H_SEED;
      end
      S_H_SEED: begin
        if (mdone) begin
          state_next = S_H_NEXT;
        end
      end
      S_H_NEXT: begin
        mstart = 1'b1;
        if (blk < whole) begin
          ma         = block(key, blk[BLK_W-2:0]);
          state_next = S_BLK1;
        end else if (tail_len != '0) begin
          ma         = h ^ block(key, whole[BLK_W-2:0]);
          state_next = S_TAIL;
        end else begin
          ma         = fold(h);
          state_next = S_FIN;
        end
      end
      S_BLK1: begin
        if (mdone) begin
          mstart     = 1'b1;
          ma         = fold(mp);
          state_next = S_BLK2;
        end
      end
      S_BLK2: begin
        if (mdone) begin
          mstart     = 1'b1;
          ma         = h ^ mp;
          state_next = S_BLK3;
        end
      end
      S_BLK3: begin
        if (mdone) begin
          state_next = S_H_NEXT;
        end
      end
      S_TAIL: begin
        if (mdone) begin
          mstart     = 1'b1;
          ma         = fold(mp);
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (mdone) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (bcnt == '0) begin
          state_next = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        state_next = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        fwe = ins;
        state_next = (seed + HC_W'(1) == cfg.nh) ? S_EMIT : S_H_INIT;
      end
      S_EMIT: begin
        if (can_emit) begin
          kmer_done  = is_kmer;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
      kv           <= 1'b0;
    end else begin
      state <= state_next;
      kv    <= (state == S_KEY_RD);
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (state == S_EMIT && can_emit) begin
        result.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        part    <= cmd_data.partition;
        ins     <= cmd_data.insert;
        is_kmer <= (cmd_data.kind == CMD_KMER);
        len_err <= (cmd_data.kind == CMD_SHORT);
        found   <= 1'b1;
        pidx    <= '0;
      end
      S_CANON_CMP: begin
        if (pidx < half && ca == cb) begin
          pidx <= pidx + 1'b1;
        end else begin
          swap <= (ca > cb);
          jidx <= '0;
          key  <= '0;
        end
      end
      S_KEY_RD: begin
        jd <= jidx;
        if (jidx != kl1) begin
          jidx <= jidx + 1'b1;
        end
      end
      S_KEY_LAST: begin
        seed <= '0;
      end
      S_H_INIT: begin
        blk <= '0;
      end
      S_H_SEED: begin
        if (mdone) begin
          h <= mp ^ 64'(seed);
        end
      end
      S_BLK3: begin
        if (mdone) begin
          h   <= mp;
          blk <= blk + 1'b1;
        end
      end
      S_FIN: begin
        if (mdone) begin
          dvd  <= fold(mp);
          rem  <= '0;
          bcnt <= 6'd63;
        end
      end
      S_MOD: begin
        // Restoring remainder, one dividend bit per cycle.
        if (r2 >= {1'b0, cfg.fs}) begin
          rem <= FS_W'(r2 - {1'b0, cfg.fs});
        end else begin
          rem <= r2[FS_W-1:0];
        end
        dvd  <= dvd << 1;
        bcnt <= bcnt - 1'b1;
      end
      S_PROBE_CHK: begin
        if (!ins && (frdata & mask) == '0) begin
          found <= 1'b0;
        end
        seed <= seed + 1'b1;
      end
      S_EMIT: begin
        if (can_emit) begin
          result.found        <= !ins && !len_err && found;
          result.length_error <= len_err;
          result.was_insert   <= ins;
        end
      end
      default: begin
      end
    endcase
    // Key bytes land in the cycle after their buffer read.
    if (kv) begin
      if (swap && jd >= pidx && jd <= kl1 - pidx) begin
        key[jd*8 +: 8] <= cb;
      end else begin
        key[jd*8 +: 8] <= ca;
      end
    end
  end

  `CKBF_ASSERT_IMP(a_mul_idle_on_start, clk, rst, mstart, !mbusy)
  `CKBF_ASSERT_IMP(a_rem_below_mod, clk, rst, state == S_MOD, rem < cfg.fs)
endmodule
`default_nettype wire

// ===== verif/ckbf_checker.sv =====
// Scoreboard for the canonical k-mer Bloom filter unit: watches the item, result and config
// channels, predicts each result and compares it. Depends on ckbf_pkg and ckbf_channels.
`default_nettype none
module ckbf_checker import ckbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ckbf_item_if   item,
  ckbf_result_if result,
  ckbf_cfg_if    cfg,
  output int     fail_count,
  output int     open_count,
  output int     result_count
);

  typedef struct packed {
    logic found;
    logic length_error;
    logic was_insert;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [KLEN_W-1:0]  set_klen;
  logic [HC_W-1:0]    set_hc;
  logic [FS_W-1:0]    set_fs;
  logic [KEY_W-1:0]   chars;
  int                 n_chars;
  logic [63:0]        words[int];

  function automatic logic [7:0] complement_base(input logic [7:0] x);
    case (x)
      8'h41, 8'h61: return 8'h54;
      8'h43, 8'h63: return 8'h47;
      8'h47, 8'h67: return 8'h43;
      8'h54, 8'h74: return 8'h41;
      default:      return 8'h4e;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] canonical_key(input logic [KEY_W-1:0] k, input int n);
    int half, p, l, r;
    logic [7:0] t;
    half = (n - 1) / 2;
    p = 0;
    while (p < half && k[8*p +: 8] == complement_base(k[8*(n-1-p) +: 8])) p++;
    if (k[8*p +: 8] > complement_base(k[8*(n-1-p) +: 8])) begin
      l = p;
      r = n - 1 - p;
      while (l <= r) begin
        t = complement_base(k[8*r +: 8]);
        k[8*r +: 8] = complement_base(k[8*l +: 8]);
        k[8*l +: 8] = t;
        l++;
        if (r == 0) break;
        r--;
      end
    end
    return k;
  endfunction

  function automatic logic [63:0] murmur_hash(input logic [KEY_W-1:0] k, input int n,
                                              input int seed);
    logic [63:0] h, w;
    int i;
    h = 64'(seed) ^ (64'(n) * MIX_M);
    for (i = 0; i < n / 8; i++) begin
      w = k[64*i +: 64];
      w = w * MIX_M;
      w = w ^ (w >> MIX_R);
      w = w * MIX_M;
      h = (h ^ w) * MIX_M;
    end
    if (n % 8 != 0) begin
      for (i = 0; i < n % 8; i++) h = h ^ (64'(k[8*((n/8)*8 + i) +: 8]) << (8 * i));
      h = h * MIX_M;
    end
    h = h ^ (h >> MIX_R);
    h = h * MIX_M;
    h = h ^ (h >> MIX_R);
    return h;
  endfunction

  task automatic take_item();
    int klen, nh, i, addr;
    logic [63:0] fs, bitno, mask;
    logic [KEY_W-1:0] key;
    logic hit;
    verdict_t v;
    if (item.op == OP_LOAD) begin
      words[int'(item.partition) * FILTER_WORDS + int'(item.word_index)] = item.word_bits;
      return;
    end
    if (item.op != OP_QUERY && item.op != OP_INSERT) return;
    klen = (set_klen == 0) ? 1 : (int'(set_klen) > MAX_KMER ? MAX_KMER : int'(set_klen));
    if (n_chars < klen) begin
      chars[8*n_chars +: 8] = item.kmer_char;
      n_chars++;
    end
    if (!item.kmer_last) return;
    v.found = 1'b0;
    v.length_error = 1'b0;
    v.was_insert = (item.op == OP_INSERT);
    if (n_chars < klen) begin
      v.length_error = 1'b1;
    end else begin
      key = canonical_key(chars, klen);
      nh = int'(set_hc) > MAX_HASHES ? MAX_HASHES : int'(set_hc);
      fs = (set_fs == 0) ? 64'd1 : 64'(set_fs);
      if (fs > 64'(FILTER_WORDS) * 64) fs = 64'(FILTER_WORDS) * 64;
      hit = 1'b1;
      for (i = 0; i < nh; i++) begin
        bitno = murmur_hash(key, klen, i) % fs;
        addr = int'(item.partition) * FILTER_WORDS + int'(bitno >> 6);
        mask = 64'd1 << (63 - int'(bitno[5:0]));
        if (!words.exists(addr)) begin
          $error("probe of filter word %0d that was never loaded", addr);
          fail_count++;
          words[addr] = '0;
        end
        if (item.op == OP_INSERT) words[addr] = words[addr] | mask;
        else if ((words[addr] & mask) == 0) hit = 1'b0;
      end
      v.found = (item.op == OP_QUERY) && hit;
    end
    n_chars = 0;
    verdict_q.insert(verdict_q.size(), v);
  endtask

  task automatic take_result();
    verdict_t e;
    result_count++;
    if (verdict_q.size() == 0) begin
      $error("result transaction with nothing expected");
      fail_count++;
      return;
    end
    e = verdict_q.pop_front();
    if (result.found !== e.found) begin
      $error("found: expected %0b, got %0b", e.found, result.found);
      fail_count++;
    end
    if (result.length_error !== e.length_error) begin
      $error("length_error: expected %0b, got %0b", e.length_error, result.length_error);
      fail_count++;
    end
    if (result.was_insert !== e.was_insert) begin
      $error("was_insert: expected %0b, got %0b", e.was_insert, result.was_insert);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    open_count = 0;
    n_chars = 0;
    chars = '0;
    set_klen = 7'd32;
    set_hc = 4'd4;
    set_fs = 21'd1048576;
  end

  always @(posedge clk) begin
    if (rst) begin
      n_chars = 0;
      set_klen = 7'd32;
      set_hc = 4'd4;
      set_fs = 21'd1048576;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KMER_LEN:    set_klen = cfg.data[KLEN_W-1:0];
          REG_HASH_COUNT:  set_hc = cfg.data[HC_W-1:0];
          REG_FILTER_SIZE: set_fs = cfg.data[FS_W-1:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) take_item();
      if (result.valid && result.ready) take_result();
    end
    open_count = verdict_q.size();
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench top for the canonical k-mer Bloom filter unit: clock, reset, stimulus, verdict.
// Depends on ckbf_pkg, ckbf_channels, the unit itself and ckbf_checker.
`default_nettype none
module tb;
  import ckbf_pkg::*;

  // Op code 3 and config index 3 are unused by the unit; both are still driven.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ckbf_item_if   item_ch ();
  ckbf_result_if res_ch ();
  ckbf_cfg_if    cfg_ch ();

  int fail_count, open_count, result_count;
  int item_taken = 0;
  int cfg_taken = 0;
  int kmers_sent = 0;
  int loads_sent = 0;
  int burst_left = 0;
  int cur_klen = 32;
  logic [7:0] last_kmer[$];

  canonical_kmer_bloom_filter_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  ckbf_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (res_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .open_count   (open_count),
    .result_count (result_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Transaction counters let the stimulus wait on handshakes at the falling edge, where the
  // value from the last rising edge has long settled.
  always @(posedge clk) begin
    if (item_ch.valid && item_ch.ready) item_taken <= item_taken + 1;
    if (cfg_ch.valid && cfg_ch.ready) cfg_taken <= cfg_taken + 1;
  end

  // The receiver switches between modes: always ready, coin-flip stalls, and mostly ready
  // with rare long stalls. Each mode lasts a random number of cycles.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(20, 300);
    end else begin
      rx_mode_left--;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      res_ch.ready <= 1'b0;
    end else if (rx_mode == 1) begin
      res_ch.ready <= $urandom_range(0, 1);
    end else if (rx_mode == 2 && $urandom_range(0, 49) == 0) begin
      rx_stall_left = $urandom_range(5, 40);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // One item transaction. The sender works in bursts; between bursts valid drops for a
  // random gap. The call starts and ends at a falling edge.
  task automatic send(input logic [1:0] op, input logic [2:0] part, input logic [7:0] ch,
                      input logic last, input logic [13:0] widx, input logic [63:0] bits);
    int seen, gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 6) == 0) ? 120 : $urandom_range(1, 30);
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.partition  <= part;
    item_ch.kmer_char  <= ch;
    item_ch.kmer_last  <= last;
    item_ch.word_index <= widx;
    item_ch.word_bits  <= bits;
    seen = item_taken;
    do @(negedge clk); while (item_taken == seen);
    if (op == OP_LOAD) loads_sent++;
    if (last && (op == OP_QUERY || op == OP_INSERT)) kmers_sent++;
  endtask

  task automatic load_word(input logic [2:0] part, input logic [13:0] widx,
                           input logic [63:0] bits);
    send(OP_LOAD, part, 8'($urandom), 1'($urandom), widx, bits);
  endtask

  // Sends a string of characters as one k-mer; only the finishing item fixes op and filter.
  task automatic send_string(input string s, input logic [1:0] op, input logic [2:0] part);
    for (int i = 0; i < s.len(); i++)
      send((i == s.len() - 1) ? op : OP_QUERY, part, s[i], i == s.len() - 1, '0, '0);
  endtask

  // Holds the sender until every expected result has come back.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  // Registers change only with the unit idle: drain, then allow a load still in flight
  // to land before the write goes out.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int seen;
    drain();
    repeat (100) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    seen = cfg_taken;
    do @(negedge clk); while (cfg_taken == seen);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_KMER_LEN)
      cur_klen = (val[6:0] == 0) ? 1 : (int'(val[6:0]) > MAX_KMER ? MAX_KMER : int'(val[6:0]));
  endtask

  task automatic configure(input int klen, input int hc, input int fs);
    write_reg(REG_KMER_LEN, CFG_DATA_W'(klen));
    write_reg(REG_HASH_COUNT, CFG_DATA_W'(hc));
    write_reg(REG_FILTER_SIZE, CFG_DATA_W'(fs));
  endtask

  // Mostly bases in either case, some N and some arbitrary bytes.
  function automatic logic [7:0] pick_char();
    int r;
    string bases;
    bases = "ACGTacgt";
    r = $urandom_range(0, 99);
    if (r < 85) return bases[$urandom_range(0, 7)];
    if (r < 90) return ASC_N;
    return 8'($urandom);
  endfunction

  // One random k-mer: usually the configured length, sometimes short or long, sometimes a
  // replay of the last inserted one as a query so that hits occur. Loads and unused-op items
  // are mixed in between the characters.
  task automatic random_kmer(input bit only_top_filter, input int word_span);
    int len, r;
    bit replay;
    logic [1:0] fin_op;
    logic [2:0] part;
    logic [7:0] ch;
    logic [7:0] chars[$];
    r = $urandom_range(0, 99);
    replay = ($urandom_range(0, 99) < 35) && last_kmer.size() > 0;
    if (replay) chars = last_kmer;
    else begin
      if (r < 70 || cur_klen == 1 && r < 85) len = cur_klen;
      else if (r < 85) len = $urandom_range(1, cur_klen - 1);
      else len = cur_klen + $urandom_range(1, 3);
      for (int i = 0; i < len; i++) chars = {chars, pick_char()};
    end
    fin_op = (replay || $urandom_range(0, 1)) ? OP_QUERY : OP_INSERT;
    part = only_top_filter ? 3'd7 : 3'($urandom_range(0, 7));
    for (int i = 0; i < chars.size(); i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        load_word(only_top_filter ? 3'd7 : 3'($urandom),
                  14'($urandom_range(0, word_span - 1)), {$urandom, $urandom});
      else if (r < 8)
        send(OP_SPARE, 3'($urandom), 8'($urandom), 1'($urandom), 14'($urandom),
             {$urandom, $urandom});
      ch = chars[i];
      if (i == chars.size() - 1) send(fin_op, part, ch, 1'b1, '0, '0);
      else send($urandom_range(0, 1) ? OP_QUERY : OP_INSERT, 3'($urandom), ch, 1'b0,
                14'($urandom), {$urandom, $urandom});
    end
    if (fin_op == OP_INSERT) last_kmer = chars;
  endtask

  task automatic random_phase(input int budget, input bit only_top_filter,
                              input int word_span);
    int start;
    start = item_taken;
    last_kmer.delete();
    while (item_taken - start < budget) random_kmer(only_top_filter, word_span);
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.op = OP_LOAD;
    item_ch.partition = '0;
    item_ch.kmer_char = '0;
    item_ch.kmer_last = 1'b0;
    item_ch.word_index = '0;
    item_ch.word_bits = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Words 0..15 of every filter are defined up front, so any filter size up to 1024
    // bits only ever probes loaded words. The first two carry the all-ones and all-zeros
    // extremes.
    for (int p = 0; p < NUM_FILTERS; p++)
      for (int w = 0; w < 16; w++)
        load_word(3'(p), 14'(w), (p == 0 && w == 0) ? '1 :
                  (p == 0 && w == 1) ? '0 : {$urandom, $urandom});

    // Directed part: a reverse-complement palindrome inserted then found, lowercase,
    // a short k-mer, characters beyond the length, odd bytes, an unused op in the middle
    // of a k-mer and a k-mer whose finishing item switches the op.
    configure(4, 3, 1024);
    send_string("ACGT", OP_INSERT, 3'd0);
    send_string("ACGT", OP_QUERY, 3'd0);
    send_string("acgt", OP_QUERY, 3'd0);
    send_string("AC", OP_QUERY, 3'd3);
    send_string("TTTTGGA", OP_INSERT, 3'd7);
    send_string("TTTT", OP_QUERY, 3'd7);
    send(OP_QUERY, 3'd1, 8'h00, 1'b0, '0, '0);
    send(OP_QUERY, 3'd1, 8'hff, 1'b0, '0, '0);
    send(OP_QUERY, 3'd1, ASC_N, 1'b0, '0, '0);
    send(OP_QUERY, 3'd1, 8'h6e, 1'b1, '0, '0);
    send(OP_QUERY, 3'd2, ASC_G, 1'b0, '0, '0);
    send(OP_SPARE, 3'd2, ASC_A, 1'b1, '1, '1);
    send_string("GCC", OP_INSERT, 3'd2);

    // Random phases; all but one get new settings, out-of-range ones among them.
    configure(1, 1, 1);
    random_phase(150, 1'b0, 16);
    configure(0, 0, 0);
    random_phase(100, 1'b0, 16);
    write_reg(REG_SPARE, 21'h1fffff);
    configure(5, 8, 1000);
    random_phase(250, 1'b0, 16);
    drain();
    random_phase(150, 1'b0, 16);
    configure(8, 2, 513);
    random_phase(250, 1'b0, 16);
    configure(17, 5, 1024);
    random_phase(250, 1'b0, 16);
    configure(3, 4, 100);
    random_phase(200, 1'b0, 16);
    configure(64, 8, 777);
    random_phase(150, 1'b0, 13);
    configure(127, 15, 64);
    random_phase(100, 1'b0, 1);

    drain();
    repeat (200) @(negedge clk);
    $display("Sent %0d k-mers and %0d filter loads over 9 register settings;",
             kmers_sent, loads_sent);
    $display("checked %0d result transactions.", result_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
